### sv/two_list_sorted_merge_top_macros.svh
// Assertion macros for the two-list sorted merge block.
// Included by the top level; depends on nothing else.
`ifndef TWO_LIST_SORTED_MERGE_TOP_MACROS_SVH
`define TWO_LIST_SORTED_MERGE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlsm assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TLSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlsm assertion failed one cycle later");

`endif

### sv/tlsm_pkg.sv
// Shared constants of the two-list sorted merge block: list depth, widths and
// request codes. Used by the channel interfaces and the top level.
package tlsm_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int VALUE_W    = 32;
   localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;
   localparam int REQ_W      = 2;

   localparam logic [REQ_W-1:0] REQ_PUSH_FIRST  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_SECOND = 2'd1;
   localparam logic [REQ_W-1:0] REQ_MERGE       = 2'd2;

endpackage

### sv/tlsm_channels.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on tlsm_pkg for the field widths.
interface tlsm_req_if;
   import tlsm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [REQ_W-1:0]          req_type;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface tlsm_rsp_if;
   import tlsm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] merged_value;
   logic                      last;
   logic                      empty_merge;

   modport source (output valid, output merged_value, output last, output empty_merge,
                   input ready);
   modport sink   (input valid, input merged_value, input last, input empty_merge,
                   output ready);
endinterface

### sv/tlsm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; the read data holds while the read enable is low.
module tlsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/two_list_sorted_merge_top.sv
// Top level of the two-list sorted merge block.
// Depends on tlsm_pkg, tlsm_channels, tlsm_ram and the assertion macro header.
//
// Usage: request beats on req_if carry a code and a signed value. A push to the
// first or second list is taken while idle and writes the value into that
// list's RAM; a push to a full list is dropped. A merge beat starts a run that
// sends the merged ascending sequence on rsp_if, one beat per element, with
// last set on the final beat. On equal heads the second list goes first. A
// merge with both lists empty sends one beat with empty_merge and last set.
// Both lists are empty again after a merge. Unused codes are taken and ignored.
// After the merge beat is taken, both list RAMs are read and the first response
// beat is registered from their read data; after that one beat per cycle while
// the receiver is ready. Requests are refused while a merge run is in progress.
// A stalled receiver holds the output register and pauses the merge run.
// Reset clears the counts, the run state and the output valid; list contents
// are not cleared; an unwritten entry may be read, but its data is never used.
`include "two_list_sorted_merge_top_macros.svh"

module two_list_sorted_merge_top (
   input logic        clock,
   input logic        reset,
   tlsm_req_if.sink   req_if,
   tlsm_rsp_if.source rsp_if
);
   import tlsm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_MERGE = 2'b10
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          first_count_ff, first_count_in;
   logic [CNT_W-1:0]          second_count_ff, second_count_in;
   logic [CNT_W-1:0]          i_ff, i_in;
   logic [CNT_W-1:0]          j_ff, j_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_empty_ff, out_empty_in;

   logic                      out_load;
   logic                      rsp_free;
   logic                      a_wr_en, b_wr_en;
   logic [ADDR_W-1:0]         a_wr_addr, b_wr_addr;
   logic                      a_rd_en, b_rd_en;
   logic [ADDR_W-1:0]         a_rd_addr, b_rd_addr;
   logic [VALUE_W-1:0]        a_rd_data, b_rd_data;
   logic [SUM_W-1:0]          total;
   logic [SUM_W-1:0]          pos_next;
   logic                      pick_first;

   tlsm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (req_if.value),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   tlsm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (req_if.value),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   assign rsp_free  = !out_valid_ff || rsp_if.ready;
   assign total     = {1'b0, first_count_ff} + {1'b0, second_count_ff};
   assign pos_next  = SUM_W'({1'b0, i_ff} + {1'b0, j_ff} + 1'b1);
   assign a_wr_addr = first_count_ff[ADDR_W-1:0];
   assign b_wr_addr = second_count_ff[ADDR_W-1:0];
   assign req_if.ready = (state_ff == ST_IDLE);

   always_comb begin
      pick_first = (i_ff < first_count_ff) &&
                   ((j_ff >= second_count_ff) ||
                    ($signed(a_rd_data) < $signed(b_rd_data)));
   end

   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      out_load        = 1'b0;
      out_valid_in    = out_valid_ff && !rsp_if.ready;
      out_value_in    = out_value_ff;
      out_last_in     = out_last_ff;
      out_empty_in    = out_empty_ff;
      a_wr_en         = 1'b0;
      b_wr_en         = 1'b0;
      a_rd_en         = 1'b0;
      b_rd_en         = 1'b0;
      a_rd_addr       = '0;
      b_rd_addr       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               case (req_if.req_type)
                  REQ_PUSH_FIRST: begin
                     if (first_count_ff < CNT_W'(LIST_DEPTH)) begin
                        a_wr_en        = 1'b1;
                        first_count_in = CNT_W'(first_count_ff + 1'b1);
                     end
                  end
                  REQ_PUSH_SECOND: begin
                     if (second_count_ff < CNT_W'(LIST_DEPTH)) begin
                        b_wr_en         = 1'b1;
                        second_count_in = CNT_W'(second_count_ff + 1'b1);
                     end
                  end
                  REQ_MERGE: begin
                     state_in = ST_MERGE;
                     i_in     = '0;
                     j_in     = '0;
                     a_rd_en  = 1'b1;
                     b_rd_en  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            if (rsp_free) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               if (total == '0) begin
                  out_value_in = '0;
                  out_last_in  = 1'b1;
                  out_empty_in = 1'b1;
               end else begin
                  out_empty_in = 1'b0;
                  out_last_in  = (pos_next == total);
                  if (pick_first) begin
                     out_value_in = $signed(a_rd_data);
                     i_in         = CNT_W'(i_ff + 1'b1);
                     a_rd_en      = (i_in < first_count_ff);
                     a_rd_addr    = i_in[ADDR_W-1:0];
                  end else begin
                     out_value_in = $signed(b_rd_data);
                     j_in         = CNT_W'(j_ff + 1'b1);
                     b_rd_en      = (j_in < second_count_ff);
                     b_rd_addr    = j_in[ADDR_W-1:0];
                  end
               end
               if (out_last_in) begin
                  state_in        = ST_IDLE;
                  first_count_in  = '0;
                  second_count_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         i_ff            <= '0;
         j_ff            <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.merged_value = out_value_ff;
   assign rsp_if.last         = out_last_ff;
   assign rsp_if.empty_merge  = out_empty_ff;

   `TLSM_ASSERT_SAME(a_pointers_in_range, clock, reset, state_ff == ST_MERGE,
      (i_ff <= first_count_ff) && (j_ff <= second_count_ff))
   `TLSM_ASSERT_SAME(a_counts_bounded, clock, reset, 1'b1,
      (first_count_ff <= CNT_W'(LIST_DEPTH)) && (second_count_ff <= CNT_W'(LIST_DEPTH)))
   `TLSM_ASSERT_NEXT(a_last_ends_run, clock, reset, out_load && out_last_in,
      (state_ff == ST_IDLE) && (first_count_ff == '0) && (second_count_ff == '0))
   `TLSM_ASSERT_NEXT(a_stall_pauses_run, clock, reset,
      (state_ff == ST_MERGE) && out_valid_ff && !rsp_if.ready,
      $stable(i_ff) && $stable(j_ff))

endmodule
